FILE: hdl/cscnt_pkg.sv
// ----------------------------------------------------------------------------
// cscnt_pkg
// Shared types and constants for the five-point stencil star counter.
// ----------------------------------------------------------------------------
package cscnt_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam int PIX_W      = 8;
  localparam int DIM_W      = 9;
  localparam int THR_W      = 11;
  localparam int SUM_W      = 11;
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int DIM_MIN    = 3;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 9'd8;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 9'd6;
  localparam logic [THR_W-1:0] THR_RESET    = 11'd30;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUM_THRESHOLD = 2'd2;

  typedef struct packed {
    logic judge;       // interior centre is judged on this pixel
    logic last_frame;  // last pixel of the frame
  } pos_flags_t;

  typedef struct packed {
    logic [PIX_W-1:0] prev;
    logic [PIX_W-1:0] older;
  } row_pair_t;

endpackage

FILE: hdl/cscnt_scan.sv
// ----------------------------------------------------------------------------
// cscnt_scan
// Configuration registers and raster position counters; flags per pixel.
// ----------------------------------------------------------------------------
module cscnt_scan
  import cscnt_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int AW         = $clog2(MAX_WIDTH),
  parameter int RW         = $clog2(MAX_HEIGHT)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  accept,
  output logic [AW-1:0]         col,
  output pos_flags_t            flags,
  output logic [THR_W-1:0]      threshold
);

  localparam int CW = (AW + 1 > DIM_W) ? AW + 1 : DIM_W;
  localparam int HW = (RW + 1 > DIM_W) ? RW + 1 : DIM_W;

  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic [RW-1:0]    row;
  logic [CW-1:0]    w_ext, w_eff, col_inc;
  logic [HW-1:0]    h_ext, h_eff, row_inc;
  logic             last_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
      threshold    <= THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:   frame_width  <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT:  frame_height <= cfg_data[DIM_W-1:0];
        REG_SUM_THRESHOLD: threshold    <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // dimensions in use saturate to 3..MAX
  always_comb begin
    w_ext = CW'(frame_width);
    h_ext = HW'(frame_height);
    if (w_ext < CW'(DIM_MIN))        w_eff = CW'(DIM_MIN);
    else if (w_ext > CW'(MAX_WIDTH)) w_eff = CW'(MAX_WIDTH);
    else                             w_eff = w_ext;
    if (h_ext < HW'(DIM_MIN))         h_eff = HW'(DIM_MIN);
    else if (h_ext > HW'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
    else                              h_eff = h_ext;
    col_inc = CW'(col) + CW'(1);
    row_inc = HW'(row) + HW'(1);
    last_col         = (col_inc >= w_eff);
    flags.last_frame = last_col && (row_inc >= h_eff);
    flags.judge      = (row >= RW'(2)) && (col != '0) && (col_inc < w_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (last_col) begin
        col <= '0;
        if (flags.last_frame) row <= '0;
        else                  row <= row_inc[RW-1:0];
      end else begin
        col <= col_inc[AW-1:0];
      end
    end
  end

endmodule

FILE: hdl/cscnt_line_store.sv
// ----------------------------------------------------------------------------
// cscnt_line_store
// Two-row line store: one word per column holds the previous and older row.
// One write port, two registered read ports.
// ----------------------------------------------------------------------------
module cscnt_line_store
  import cscnt_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_WIDTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr_a,
  input  logic [AW-1:0]    rd_addr_b,
  output row_pair_t        rd_data_a,
  output logic [PIX_W-1:0] rd_prev_b,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  row_pair_t        wr_data
);

  row_pair_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_prev_b <= mem[rd_addr_b].prev;
    end
  end

endmodule

FILE: hdl/cscnt_judge.sv
// ----------------------------------------------------------------------------
// cscnt_judge
// Stencil stage: five-point sum, threshold test, star counter, line store
// write-back and the result register.
// ----------------------------------------------------------------------------
module cscnt_judge
  import cscnt_pkg::*;
#(
  parameter int AW = $clog2(DEF_MAX_WIDTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [PIX_W-1:0] pixel,
  input  pos_flags_t       flags,
  input  logic [AW-1:0]    col,
  input  logic [THR_W-1:0] threshold,
  input  row_pair_t        cur,
  input  logic [PIX_W-1:0] right_px,
  output logic             in_ready,
  output logic             wr_en,
  output logic [AW-1:0]    wr_addr,
  output row_pair_t        wr_data,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [CNT_W-1:0] m_tdata
);

  logic             s1_valid;
  logic [PIX_W-1:0] s1_pixel;
  pos_flags_t       s1_flags;
  logic [AW-1:0]    s1_col;
  logic [PIX_W-1:0] left_px;
  logic [CNT_W-1:0] star_counter;
  logic [CNT_W-1:0] count_next;
  logic [SUM_W-1:0] sum;
  logic             star;
  logic             adv;

  // a frame end must wait while the result register is still full
  assign adv      = !s1_valid || !s1_flags.last_frame || !m_tvalid || m_tready;
  assign in_ready = adv;

  always_comb begin
    sum = SUM_W'(s1_pixel) + SUM_W'(cur.older) + SUM_W'(cur.prev)
        + SUM_W'(right_px) + SUM_W'(left_px);
    star       = s1_flags.judge && (sum > threshold);
    count_next = star_counter + CNT_W'(star);
  end

  // shift at this column: older <- previous, previous <- pixel
  assign wr_en        = s1_valid && adv;
  assign wr_addr      = s1_col;
  assign wr_data.prev  = s1_pixel;
  assign wr_data.older = cur.prev;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (adv) s1_valid <= accept;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel <= pixel;
      s1_flags <= flags;
      s1_col   <= col;
    end
    // left neighbour is the centre read of the pixel before
    if (s1_valid && adv) left_px <= cur.prev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      star_counter <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (s1_valid && adv) begin
        if (s1_flags.last_frame) begin
          star_counter <= '0;
        end else begin
          star_counter <= count_next;
        end
      end
      if (s1_valid && adv && s1_flags.last_frame) m_tvalid <= 1'b1;
      else if (m_tready)                          m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && adv && s1_flags.last_frame) m_tdata <= count_next;
  end

  a_hold_frame_end: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_flags.last_frame && m_tvalid && !m_tready) |-> !in_ready)
    else $error("frame end passed a full result register");

  a_clear_after_frame: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && adv && s1_flags.last_frame) |=> (star_counter == '0) && m_tvalid)
    else $error("star counter not cleared at frame end");

  a_border_no_count: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && adv && !s1_flags.last_frame && !s1_flags.judge)
      |=> star_counter == $past(star_counter))
    else $error("border pixel changed the star counter");

  a_stall_no_write: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !adv) |-> (!wr_en && !accept))
    else $error("line store written or item taken during stall");

endmodule

FILE: hdl/cross_stencil_star_count.sv
// ----------------------------------------------------------------------------
// cross_stencil_star_count
// Five-point stencil star counter over a raster pixel stream.
// ----------------------------------------------------------------------------
// Throughput: one pixel per clock outside a stall; a pixel is taken while a frame total waits.
// Frame total: the frame's last pixel passes the input and line store read
//   registers, then the stencil stage, into the result register.
// Stall: only a frame end meeting a still-full result register holds the input.
// Reset (rst, synchronous): positions, counter and valids clear, registers
//   return to 8 x 6 and threshold 30; line store contents are kept.
// ----------------------------------------------------------------------------
module cross_stencil_star_count
  import cscnt_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] pixel_value
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata,   // [15:0] star_total
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic             accept;
  logic [AW-1:0]    col;
  logic [AW-1:0]    col_right;
  pos_flags_t       flags;
  logic [THR_W-1:0] threshold;
  row_pair_t        cur;
  logic [PIX_W-1:0] right_px;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  row_pair_t        wr_data;

  assign accept    = s_tvalid && s_tready;
  assign col_right = col + AW'(1);

  cscnt_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW),
    .RW         (RW)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .col       (col),
    .flags     (flags),
    .threshold (threshold)
  );

  cscnt_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_store (
    .clk       (clk),
    .rd_en     (accept),
    .rd_addr_a (col),
    .rd_addr_b (col_right),
    .rd_data_a (cur),
    .rd_prev_b (right_px),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  cscnt_judge #(
    .AW (AW)
  ) u_judge (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .pixel     (s_tdata[PIX_W-1:0]),
    .flags     (flags),
    .col       (col),
    .threshold (threshold),
    .cur       (cur),
    .right_px  (right_px),
    .in_ready  (s_tready),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
